>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define CIA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("check failed");

// Clocked check that also holds during reset.
`define CIA_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("check failed during reset");

`endif

>>> hw/rtl/cia_pkg.sv
`default_nettype none

package cia_pkg;

  localparam int unsigned ResW       = 34;
  localparam int unsigned OperandWDef = 16;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_NE  = 3'd5
  } cia_op_e;

endpackage

`default_nettype wire

>>> hw/rtl/complex_integer_alu.sv
// Gaussian integer ALU: add, subtract, multiply, divide, equal, not equal.
// Input channel: in_valid_i / in_stall_o with opcode_i and the operand parts
// a_re_i, a_im_i, b_re_i, b_im_i. Output channel: out_valid_o / out_stall_i
// with res_re_o, res_im_o, cmp_true_o, div_zero_o. A transfer happens on an
// edge where valid is high and stall is low.
// Every item produces exactly one result, in order. Throughput is one item
// per cycle while the receiver does not stall. Every opcode passes through
// one multiply stage, one add stage, one magnitude stage, one
// restoring-divider stage per quotient bit (2*OPERAND_WIDTH of them),
// and one sign/select stage that feeds the output register.
// Divide returns the truncated quotient of a*conj(b) by |b|^2; with b zero
// it returns zero and raises div_zero_o.
// Reset empties all stages; no result is shown until items arrive.
// When the receiver stalls, the output holds and empty stages behind it
// still fill, so in_stall_o rises only once the whole pipeline is full.
`default_nettype none

module complex_integer_alu
  import cia_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OperandWDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [2:0]                      opcode_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_re_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_im_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_re_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_im_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic signed [ResW-1:0]          res_re_o,
  output      logic signed [ResW-1:0]          res_im_o,
  output      logic                            cmp_true_o,
  output      logic                            div_zero_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned NW = 2 * W;   // quotient / magnitude bits
  localparam int unsigned NQ = NW;      // divider stages
  localparam int unsigned EW = (2 * W + 2 > ResW) ? 2 * W + 2 : ResW;

  typedef struct packed {
    logic [2:0]          op;
    logic                cmp;
    logic signed [W:0]   sum_re;
    logic signed [W:0]   sum_im;
    logic signed [W:0]   dif_re;
    logic signed [W:0]   dif_im;
    logic signed [NW-1:0] p_rr;
    logic signed [NW-1:0] p_ii;
    logic signed [NW-1:0] p_ri;
    logic signed [NW-1:0] p_ir;
    logic signed [NW-1:0] p_bb_r;
    logic signed [NW-1:0] p_bb_i;
  } s1_t;

  typedef struct packed {
    logic [ResW-1:0]     fast_re;
    logic [ResW-1:0]     fast_im;
    logic                cmp;
    logic                dz;
    logic                is_div;
    logic signed [NW:0]  num_re;
    logic signed [NW:0]  num_im;
    logic [NW-1:0]       den;
  } s2_t;

  typedef struct packed {
    logic [ResW-1:0] fast_re;
    logic [ResW-1:0] fast_im;
    logic            cmp;
    logic            dz;
    logic            is_div;
    logic            neg_re;
    logic            neg_im;
    logic [NW-1:0]   den;
    logic [NW-1:0]   num_re;
    logic [NW-1:0]   num_im;
    logic [NW-1:0]   rem_re;
    logic [NW-1:0]   rem_im;
    logic [NW-1:0]   q_re;
    logic [NW-1:0]   q_im;
  } div_t;

  // ---------------------------------------------------------------- handshake
  logic          v1_q, v2_q, vo_q;
  logic [NQ:0]   dv_q;
  logic          rdy1, rdy2, rdy_out;
  logic [NQ:0]   rdy_d;

  assign rdy_out = !vo_q || !out_stall_i;
  for (genvar k = 0; k <= NQ; k++) begin : g_rdy
    if (k == NQ) begin : g_last
      assign rdy_d[k] = !dv_q[k] || rdy_out;
    end else begin : g_mid
      assign rdy_d[k] = !dv_q[k] || rdy_d[k+1];
    end
  end
  assign rdy2 = !v2_q || rdy_d[0];
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q <= in_valid_i;
      if (rdy2)    v2_q <= v1_q;
      if (rdy_out) vo_q <= dv_q[NQ];
    end
  end

  // ------------------------------------------------------- stage 1: products
  s1_t s1_d, s1_q;

  always_comb begin
    s1_d        = '0;
    s1_d.op     = opcode_i;
    s1_d.cmp    = (a_re_i == b_re_i) && (a_im_i == b_im_i);
    s1_d.sum_re = (W+1)'(a_re_i) + (W+1)'(b_re_i);
    s1_d.sum_im = (W+1)'(a_im_i) + (W+1)'(b_im_i);
    s1_d.dif_re = (W+1)'(a_re_i) - (W+1)'(b_re_i);
    s1_d.dif_im = (W+1)'(a_im_i) - (W+1)'(b_im_i);
    s1_d.p_rr   = NW'(a_re_i) * NW'(b_re_i);
    s1_d.p_ii   = NW'(a_im_i) * NW'(b_im_i);
    s1_d.p_ri   = NW'(a_re_i) * NW'(b_im_i);
    s1_d.p_ir   = NW'(a_im_i) * NW'(b_re_i);
    s1_d.p_bb_r = NW'(b_re_i) * NW'(b_re_i);
    s1_d.p_bb_i = NW'(b_im_i) * NW'(b_im_i);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
  end

  // ----------------------------------------------------------- stage 2: sums
  s2_t s2_d, s2_q;
  logic signed [EW-1:0] x_re, x_im;
  logic [NW-1:0]        den_d;

  always_comb begin
    s2_d        = '0;
    x_re        = '0;
    x_im        = '0;
    den_d       = NW'(s1_q.p_bb_r) + NW'(s1_q.p_bb_i);
    s2_d.num_re = (NW+1)'(s1_q.p_rr) + (NW+1)'(s1_q.p_ii);
    s2_d.num_im = (NW+1)'(s1_q.p_ir) - (NW+1)'(s1_q.p_ri);
    s2_d.den    = den_d;
    case (s1_q.op)
      OP_ADD: begin
        x_re = EW'(s1_q.sum_re);
        x_im = EW'(s1_q.sum_im);
      end
      OP_SUB: begin
        x_re = EW'(s1_q.dif_re);
        x_im = EW'(s1_q.dif_im);
      end
      OP_MUL: begin
        x_re = EW'(s1_q.p_rr) - EW'(s1_q.p_ii);
        x_im = EW'(s1_q.p_ri) + EW'(s1_q.p_ir);
      end
      OP_DIV: begin
        s2_d.dz     = (den_d == '0);
        s2_d.is_div = (den_d != '0);
      end
      OP_EQ:   s2_d.cmp = s1_q.cmp;
      OP_NE:   s2_d.cmp = !s1_q.cmp;
      default: ;
    endcase
    s2_d.fast_re = x_re[ResW-1:0];
    s2_d.fast_im = x_im[ResW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) s2_q <= s2_d;
  end

  // ------------------------------------------------ stage 3: divider entry
  div_t d_q [NQ+1];
  div_t d0_d;
  logic [NW:0] mag_re, mag_im;

  always_comb begin
    mag_re         = s2_q.num_re[NW] ? (NW+1)'(-s2_q.num_re) : (NW+1)'(s2_q.num_re);
    mag_im         = s2_q.num_im[NW] ? (NW+1)'(-s2_q.num_im) : (NW+1)'(s2_q.num_im);
    d0_d           = '0;
    d0_d.fast_re   = s2_q.fast_re;
    d0_d.fast_im   = s2_q.fast_im;
    d0_d.cmp       = s2_q.cmp;
    d0_d.dz        = s2_q.dz;
    d0_d.is_div    = s2_q.is_div;
    d0_d.neg_re    = s2_q.num_re[NW];
    d0_d.neg_im    = s2_q.num_im[NW];
    d0_d.den       = s2_q.den;
    d0_d.num_re    = mag_re[NW-1:0];
    d0_d.num_im    = mag_im[NW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (rdy_d[0]) begin
      dv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d[0]) d_q[0] <= d0_d;
  end

  // ---------------------------------- restoring divider, one bit per stage
  for (genvar k = 1; k <= NQ; k++) begin : g_div
    logic [NW:0] tr_re, tr_im, dn;
    div_t        nx;

    always_comb begin
      nx     = d_q[k-1];
      dn     = {1'b0, d_q[k-1].den};
      tr_re  = {d_q[k-1].rem_re, d_q[k-1].num_re[NW-1]};
      tr_im  = {d_q[k-1].rem_im, d_q[k-1].num_im[NW-1]};
      nx.num_re = {d_q[k-1].num_re[NW-2:0], 1'b0};
      nx.num_im = {d_q[k-1].num_im[NW-2:0], 1'b0};
      if (tr_re >= dn) begin
        nx.rem_re = NW'(tr_re - dn);
        nx.q_re   = {d_q[k-1].q_re[NW-2:0], 1'b1};
      end else begin
        nx.rem_re = tr_re[NW-1:0];
        nx.q_re   = {d_q[k-1].q_re[NW-2:0], 1'b0};
      end
      if (tr_im >= dn) begin
        nx.rem_im = NW'(tr_im - dn);
        nx.q_im   = {d_q[k-1].q_im[NW-2:0], 1'b1};
      end else begin
        nx.rem_im = tr_im[NW-1:0];
        nx.q_im   = {d_q[k-1].q_im[NW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (rdy_d[k]) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy_d[k]) d_q[k] <= nx;
    end
  end

  // ------------------------------------------------ sign fixup and select
  logic signed [NW:0]   qs_re, qs_im;
  logic signed [EW-1:0] qx_re, qx_im;
  logic [ResW-1:0]      res_re_d, res_im_d, res_re_q, res_im_q;
  logic                 cmp_q, dz_q;

  always_comb begin
    qs_re = d_q[NQ].neg_re ? -$signed({1'b0, d_q[NQ].q_re}) : $signed({1'b0, d_q[NQ].q_re});
    qs_im = d_q[NQ].neg_im ? -$signed({1'b0, d_q[NQ].q_im}) : $signed({1'b0, d_q[NQ].q_im});
    qx_re = EW'(qs_re);
    qx_im = EW'(qs_im);
    if (d_q[NQ].is_div) begin
      res_re_d = qx_re[ResW-1:0];
      res_im_d = qx_im[ResW-1:0];
    end else begin
      res_re_d = d_q[NQ].fast_re;
      res_im_d = d_q[NQ].fast_im;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      cmp_q    <= d_q[NQ].cmp;
      dz_q     <= d_q[NQ].dz;
    end
  end

  assign out_valid_o = vo_q;
  assign res_re_o    = res_re_q;
  assign res_im_o    = res_im_q;
  assign cmp_true_o  = cmp_q;
  assign div_zero_o  = dz_q;

endmodule

`default_nettype wire

>>> hw/rtl/cia_checker.sv
`default_nettype none

`include "assert_macros.svh"

module cia_checker
  import cia_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire logic [ResW-1:0] res_re_o,
  input wire logic [ResW-1:0] res_im_o,
  input wire logic            cmp_true_o,
  input wire logic            div_zero_o
);

  `CIA_ASSERT_RST(a_rst_empty, !rst_ni |-> !out_valid_o)

  `CIA_ASSERT(a_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(res_re_o) && $stable(res_im_o) && $stable(cmp_true_o) && $stable(div_zero_o))

  `CIA_ASSERT(a_dz_zero, out_valid_o && div_zero_o |-> res_re_o == '0 && res_im_o == '0 && !cmp_true_o)

  `CIA_ASSERT(a_cmp_zero, out_valid_o && cmp_true_o |-> res_re_o == '0 && res_im_o == '0 && !div_zero_o)

endmodule

bind complex_integer_alu cia_checker u_cia_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
  import cia_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OpW = OperandWDef;
  localparam int NumRandom = 1600;

  typedef logic signed [OpW-1:0] opnd_t;
  typedef logic signed [ResW-1:0] res_t;

  typedef struct packed {
    res_t re;
    res_t im;
    logic cmp;
    logic dz;
  } alu_result_t;

  class alu_result_board;
    alu_result_t pending_results[$];
    bit failed;

    function void note_item(logic [2:0] op, opnd_t ar_i, opnd_t ai_i, opnd_t br_i,
                            opnd_t bi_i);
      longint ar, ai, br, bi, re, im, den;
      alu_result_t r;
      ar = longint'(ar_i);
      ai = longint'(ai_i);
      br = longint'(br_i);
      bi = longint'(bi_i);
      re = 0;
      im = 0;
      r = '0;
      case (op)
        OP_ADD: begin
          re = ar + br;
          im = ai + bi;
        end
        OP_SUB: begin
          re = ar - br;
          im = ai - bi;
        end
        OP_MUL: begin
          re = ar * br - ai * bi;
          im = ar * bi + ai * br;
        end
        OP_DIV: begin
          den = br * br + bi * bi;
          if (den == 0) begin
            r.dz = 1'b1;
          end else begin
            // SV signed division truncates toward zero
            re = (ar * br + ai * bi) / den;
            im = (ai * br - ar * bi) / den;
          end
        end
        OP_EQ: r.cmp = (ar == br) && (ai == bi);
        OP_NE: r.cmp = !((ar == br) && (ai == bi));
        default: ;
      endcase
      r.re = re[ResW-1:0];
      r.im = im[ResW-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(res_t re, res_t im, logic cmp, logic dz);
      alu_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d cmp=%0b dz=%0b",
                 $time, re, im, cmp, dz);
        failed = 1;
        return;
      end
      e = pending_results.pop_front();
      if (re !== e.re) begin
        $display("%0t: res_re expected %0d actual %0d", $time, e.re, re);
        failed = 1;
      end
      if (im !== e.im) begin
        $display("%0t: res_im expected %0d actual %0d", $time, e.im, im);
        failed = 1;
      end
      if (cmp !== e.cmp) begin
        $display("%0t: cmp_true expected %0b actual %0b", $time, e.cmp, cmp);
        failed = 1;
      end
      if (dz !== e.dz) begin
        $display("%0t: div_zero expected %0b actual %0b", $time, e.dz, dz);
        failed = 1;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] opcode_i = '0;
  opnd_t a_re_i = '0, a_im_i = '0, b_re_i = '0, b_im_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  res_t res_re_o, res_im_o;
  logic cmp_true_o, div_zero_o;

  alu_result_board board = new();
  bit quiet = 0;
  int stall_left = 0;

  always #6 clk_i = ~clk_i;

  complex_integer_alu dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i,
    .a_re_i, .a_im_i, .b_re_i, .b_im_i,
    .out_valid_o, .out_stall_i, .res_re_o, .res_im_o, .cmp_true_o, .div_zero_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      board.note_item(opcode_i, a_re_i, a_im_i, b_re_i, b_im_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(res_re_o, res_im_o, cmp_true_o, div_zero_o);
  end

  // receiver back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send(logic [2:0] op, opnd_t ar, opnd_t ai, opnd_t br, opnd_t bi);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    a_re_i <= ar;
    a_im_i <= ai;
    b_re_i <= br;
    b_im_i <= bi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic opnd_t rand_opnd();
    case ($urandom_range(0, 3))
      0: return opnd_t'(int'($urandom_range(0, 15)) - 8);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return opnd_t'($urandom());
    endcase
  endfunction

  initial begin
    logic [2:0] op;
    opnd_t ar, ai, br, bi;
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < 8; k++) send(3'(k), 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send(OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send(OP_DIV, 16'sd5, -16'sd3, 16'sd0, 16'sd0);
    send(OP_DIV, 16'sh8000, 16'sh8000, 16'sd1, 16'sd0);
    send(OP_DIV, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
    send(OP_DIV, -16'sd7, 16'sd7, 16'sd2, 16'sd1);
    send(OP_DIV, 16'sd1, 16'sd1, 16'sd0, -16'sd3);
    send(OP_EQ, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send(OP_NE, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send(OP_EQ, 16'sd3, 16'sd4, 16'sd3, 16'sd5);
    send(OP_SUB, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send(OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 200) quiet = 1;
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      ar = rand_opnd();
      ai = rand_opnd();
      br = rand_opnd();
      bi = rand_opnd();
      if ((op == OP_EQ || op == OP_NE) && $urandom_range(0, 1)) begin
        br = ar;
        bi = $urandom_range(0, 2) ? ai : ai ^ opnd_t'(1 << $urandom_range(0, OpW - 1));
      end
      if (op == OP_DIV) begin
        case ($urandom_range(0, 5))
          0: begin br = '0; bi = '0; end
          1: bi = '0;
          2: br = '0;
          default: ;
        endcase
      end
      send(op, ar, ai, br, bi);
    end
    in_valid_i <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * OpW + 8) @(posedge clk_i);
    if (!board.failed && board.pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire
